FILE: src/aes128_block_encrypt_simple_keys_core_assert.svh
// Assertion macros for the AES-128 encryption core.
// Used by the top level only; needs signals named clk and rst in scope.
`ifndef AES128_BLOCK_ENCRYPT_SIMPLE_KEYS_CORE_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_SIMPLE_KEYS_CORE_ASSERT_SVH

// Implication checked on every clock, masked during reset.
`define AESK_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication whose consequent is checked on the next clock.
`define AESK_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/aesk_pkg.sv
// Shared types, constants and round functions for the AES-128 encryption core.
// No dependencies.
package aesk_pkg;

  localparam int ROUNDS = 10;
  localparam int CNT_W  = 4;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;

  typedef logic [127:0] state_t;
  typedef logic [ROUNDS:0][127:0] rkeys_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Byte b of a state sits at bits 127-8b downto 120-8b.
  function automatic logic [7:0] get_byte(state_t s, int b);
    return s[127 - 8 * b -: 8];
  endfunction

  function automatic logic [7:0] times2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic state_t sub_shift(state_t s);
    state_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (c * 4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    return t;
  endfunction

  function automatic state_t mix_columns(state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c * 4);
      a1 = get_byte(s, c * 4 + 1);
      a2 = get_byte(s, c * 4 + 2);
      a3 = get_byte(s, c * 4 + 3);
      d0 = times2(a0);
      d1 = times2(a1);
      d2 = times2(a2);
      d3 = times2(a3);
      t[127 - 8 * (c * 4)     -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      t[127 - 8 * (c * 4 + 1) -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      t[127 - 8 * (c * 4 + 2) -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      t[127 - 8 * (c * 4 + 3) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
    return t;
  endfunction

  // Next round key: byte j is the S-boxed last byte of the previous key
  // XOR the prefix XOR of the previous key's bytes 0..j.
  function automatic state_t next_round_key(state_t p);
    state_t     k;
    logic [7:0] t;
    logic [7:0] acc;
    k = '0;
    t = SBOX[p[7:0]];
    for (int j = 0; j < 16; j++) begin
      acc = t;
      for (int i = 0; i < 16; i++) begin
        if (i <= j) begin
          acc = acc ^ get_byte(p, i);
        end
      end
      k[127 - 8 * j -: 8] = acc;
    end
    return k;
  endfunction

endpackage

FILE: src/aesk_round.sv
// One pipeline stage of the cipher: SubBytes, ShiftRows, optional MixColumns,
// AddRoundKey, with an elastic valid/ready register. Depends on aesk_pkg.
module aesk_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            mix_en,
  input  aesk_pkg::state_t rkey,
  input  logic            up_valid,
  output logic            up_ready,
  input  aesk_pkg::state_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output aesk_pkg::state_t dn_data
);
  import aesk_pkg::*;

  state_t subbed;
  state_t mixed;
  state_t data;
  logic   valid;

  assign subbed   = sub_shift(up_data);
  assign mixed    = mix_en ? mix_columns(subbed) : subbed;
  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= mixed ^ rkey;
    end
  end

endmodule

FILE: src/aesk_kexp.sv
// Key registers and round key expansion, one round key per cycle after a
// key write or reset, restarting on each config write. Depends on aesk_pkg.
module aesk_kexp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  output aesk_pkg::rkeys_t  rkeys,
  output logic              busy
);
  import aesk_pkg::*;

  logic [63:0]      key_high;
  logic [63:0]      key_low;
  state_t           rk [1:ROUNDS];
  logic [CNT_W-1:0] cnt;
  state_t           prev;

  assign prev = (cnt == CNT_W'(1)) ? {key_high, key_low} : rk[cnt - CNT_W'(1)];
  assign busy = (cnt != '0);

  always_comb begin
    rkeys[0] = {key_high, key_low};
    for (int r = 1; r <= ROUNDS; r++) begin
      rkeys[r] = rk[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      cnt      <= CNT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
      cnt <= CNT_W'(1);
    end else if (busy) begin
      cnt <= (cnt == CNT_W'(ROUNDS)) ? '0 : cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !cfg_valid) begin
      rk[cnt] <= next_round_key(prev);
    end
  end

endmodule

FILE: src/aes128_block_encrypt_simple_keys_core.sv
// Top level of the AES-128 style encryption core with simplified key schedule.
// Depends on aesk_pkg, aesk_kexp, aesk_round and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready, block_high/block_low) takes one 128-bit
//   plaintext block per transaction; output channel (out_valid/out_ready,
//   cipher_high/cipher_low) returns the ciphertext, one per input, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_index/cfg_data) writes key_high
//   (index 0) or key_low (index 1); other indexes write no key. cfg_ready is
//   always high. Write keys only while no block is in flight.
//   After reset or any config write, the round key sequencer computes one
//   round key per cycle; in_ready stays low while it runs.
//   The datapath is 11 register stages: the initial key addition, then one
//   stage per round. Throughput is one block per cycle outside key expansion.
//   When the receiver stalls, the stalled stages hold their data and ready
//   backs up stage by stage to the input; nothing is dropped or duplicated.
//   Reset (synchronous, active high) empties the pipeline and clears the key.
`include "aes128_block_encrypt_simple_keys_core_assert.svh"

module aes128_block_encrypt_simple_keys_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aesk_pkg::*;

  rkeys_t rkeys;
  logic   busy;
  state_t data  [0:ROUNDS];
  logic   valid [0:ROUNDS];
  logic   ready [0:ROUNDS];
  logic   stage0_ready;
  state_t stage0_data;
  logic   stage0_valid;

  assign cfg_ready = 1'b1;

  aesk_kexp u_kexp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rkeys     (rkeys),
    .busy      (busy)
  );

  // Stage 0: initial key addition.
  assign stage0_ready = !stage0_valid || ready[0];
  assign in_ready     = stage0_ready && !busy;
  assign valid[0]     = stage0_valid;
  assign data[0]      = stage0_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage0_valid <= 1'b0;
    end else if (stage0_ready) begin
      stage0_valid <= in_valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage0_data <= {block_high, block_low} ^ rkeys[0];
    end
  end

  for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
    aesk_round u_round (
      .clk      (clk),
      .rst      (rst),
      .mix_en   (r != ROUNDS),
      .rkey     (rkeys[r]),
      .up_valid (valid[r-1]),
      .up_ready (ready[r-1]),
      .up_data  (data[r-1]),
      .dn_valid (valid[r]),
      .dn_ready (ready[r]),
      .dn_data  (data[r])
    );
  end

  assign ready[ROUNDS] = out_ready;
  assign out_valid     = valid[ROUNDS];
  assign cipher_high   = data[ROUNDS][127:64];
  assign cipher_low    = data[ROUNDS][63:0];

  `AESK_ASSERT_IMP(a_no_accept_busy, busy, !in_ready, "input accepted during key expansion")
  `AESK_ASSERT_NEXT(a_cfg_restarts, cfg_valid, busy, "key write did not restart expansion")
  `AESK_ASSERT_NEXT(a_stage0_load, in_valid && in_ready, stage0_valid, "accepted block not loaded")

endmodule
